FILE: hdl/mcrst_pkg.sv
// Shared constants, codes, functions and control types of the ring slot tracker.
package mcrst_pkg;

    localparam int MAX_SLOTS     = 16;
    localparam int MAX_CONSUMERS = 8;

    localparam int SEQ_W       = 64;
    localparam int SLOT_W      = 4;
    localparam int CID_W       = 3;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int SLOT_CNT_W  = 5;
    localparam int CONS_CNT_W  = 4;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 5;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 8;

    // residue unit: one nibble of a sequence per cycle
    localparam int DIGITS      = SEQ_W / 4;
    localparam int DIG_W       = 4;
    // lanes 0..MAX_CONSUMERS-1 are read sequences, lane MAX_CONSUMERS is the write sequence
    localparam int LANE_W      = 4;

    localparam logic [CMD_W-1:0] CMD_PROD_ACQ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROD_REL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CONS_ACQ = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CONS_REL = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOCLAIM = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD     = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_COUNT     = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CONSUMER_COUNT = 1'd1;

    localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT_RST     = 5'd16;
    localparam logic [CONS_CNT_W-1:0] CONSUMER_COUNT_RST = 4'd1;

    typedef struct packed {
        logic              load;
        logic              scan_step;
        logic              exec;
        logic              mod_step;
        logic              mod_first;
        logic              mod_wr;
        logic              mod_sel_ws;
        logic [CID_W-1:0]  rd_addr;
        logic [DIG_W-1:0]  mod_digit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic              out_busy;
        logic              slot_cfg_wr;
        logic [CID_W-1:0]  nc_last;
    } dp_status_t;

    function automatic logic [SLOT_CNT_W-1:0] eff_slots(input logic [SLOT_CNT_W-1:0] cnt);
        logic [SLOT_CNT_W-1:0] r;
        r = cnt;
        if (cnt == '0) r = SLOT_CNT_W'(1);
        else if (cnt > SLOT_CNT_W'(MAX_SLOTS)) r = SLOT_CNT_W'(MAX_SLOTS);
        return r;
    endfunction

    function automatic logic [CONS_CNT_W-1:0] eff_consumers(input logic [CONS_CNT_W-1:0] cnt);
        logic [CONS_CNT_W-1:0] r;
        r = cnt;
        if (cnt == '0) r = CONS_CNT_W'(1);
        else if (cnt > CONS_CNT_W'(MAX_CONSUMERS)) r = CONS_CNT_W'(MAX_CONSUMERS);
        return r;
    endfunction

endpackage

FILE: hdl/mcrst_ctrl.sv
// Controller state machine: request sequencing, minimum scan and residue rebuild.
module mcrst_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mcrst_pkg::CMD_W-1:0]       in_cmd,
    input  mcrst_pkg::dp_status_t             status,
    output mcrst_pkg::ctrl_cmd_t              cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_EXEC   = 4'b0100,
        S_RECOMP = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic [mcrst_pkg::CID_W-1:0]         cnt_reg, cnt_next;
    logic [mcrst_pkg::LANE_W-1:0]        lane_reg, lane_next;
    logic [mcrst_pkg::DIG_W-1:0]         digit_reg, digit_next;
    logic                                pend_reg, pend_next;
    logic                                pend_clr;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lane_next  = lane_reg;
        digit_next = digit_reg;
        pend_clr   = 1'b0;
        cmd        = '0;
        s_tready   = (state_reg == S_IDLE) && !pend_reg;

        case (state_reg)
            S_IDLE: begin
                if (pend_reg) begin
                    pend_clr   = 1'b1;
                    lane_next  = '0;
                    digit_next = mcrst_pkg::DIG_W'(mcrst_pkg::DIGITS - 1);
                    state_next = S_RECOMP;
                end else if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (in_cmd == mcrst_pkg::CMD_PROD_ACQ) begin
                        cnt_next   = '0;
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                cmd.rd_addr   = cnt_reg;
                if (cnt_reg == status.nc_last) begin
                    state_next = S_EXEC;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_EXEC: begin
                // hold until the output register can take the result
                if (!status.out_busy) begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RECOMP: begin
                cmd.mod_step   = 1'b1;
                cmd.mod_first  = (digit_reg == mcrst_pkg::DIG_W'(mcrst_pkg::DIGITS - 1));
                cmd.mod_digit  = digit_reg;
                cmd.rd_addr    = lane_reg[mcrst_pkg::CID_W-1:0];
                cmd.mod_sel_ws = (lane_reg == mcrst_pkg::LANE_W'(mcrst_pkg::MAX_CONSUMERS));
                if (digit_reg == '0) begin
                    cmd.mod_wr = 1'b1;
                    digit_next = mcrst_pkg::DIG_W'(mcrst_pkg::DIGITS - 1);
                    if (cmd.mod_sel_ws) begin
                        state_next = S_IDLE;
                    end else begin
                        lane_next = lane_reg + 1'b1;
                    end
                end else begin
                    digit_next = digit_reg - 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // a slot count write during a rebuild forces another one
        pend_next = (pend_reg && !pend_clr) || status.slot_cfg_wr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            lane_reg  <= '0;
            digit_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lane_reg  <= lane_next;
            digit_reg <= digit_next;
            pend_reg  <= pend_next;
        end
    end

`ifndef SYNTH
    a_accept_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_SCAN || state_reg == S_EXEC))
        else $error("accepted request did not start work");
`endif

endmodule

FILE: hdl/mcrst_dp.sv
// Datapath: sequences, slot residues, claim masks, minimum scan and result register.
module mcrst_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [mcrst_pkg::CMD_W-1:0]           in_cmd,
    input  logic [mcrst_pkg::CID_W-1:0]           in_id,
    input  logic                                  cfg_wr_en,
    input  logic [mcrst_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mcrst_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  mcrst_pkg::ctrl_cmd_t                  cmd,
    output mcrst_pkg::dp_status_t                 status,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mcrst_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int SEQ_W  = mcrst_pkg::SEQ_W;
    localparam int SLOT_W = mcrst_pkg::SLOT_W;
    localparam int NCONS  = mcrst_pkg::MAX_CONSUMERS;
    localparam int NSLOTS = mcrst_pkg::MAX_SLOTS;

    logic [mcrst_pkg::SLOT_CNT_W-1:0] slot_count_reg;
    logic [mcrst_pkg::CONS_CNT_W-1:0] consumer_count_reg;
    logic [mcrst_pkg::SLOT_CNT_W-1:0] ns;
    logic [mcrst_pkg::CONS_CNT_W-1:0] nc;

    logic [mcrst_pkg::CMD_W-1:0]      req_cmd_reg;
    logic [mcrst_pkg::CID_W-1:0]      req_id_reg;
    logic [SEQ_W-1:0]                 min_reg;
    logic [SLOT_W-1:0]                rem_reg;

    logic [SEQ_W-1:0]                 ws_reg;
    logic [SEQ_W-1:0]                 rs_reg    [NCONS];
    logic [SLOT_W-1:0]                wslot_reg;
    logic [SLOT_W-1:0]                rslot_reg [NCONS];
    logic [NCONS-1:0]                 mask_reg  [NSLOTS];

    logic                             m_valid_reg;
    logic [mcrst_pkg::M_TDATA_W-1:0]  m_data_reg;

    logic [mcrst_pkg::CID_W-1:0]      addr;
    logic [SEQ_W-1:0]                 rs_sel;
    logic [SEQ_W-1:0]                 mod_val;
    logic [3:0]                       nib;
    logic [SLOT_W-1:0]                rem_next;

    logic                             res_ok;
    logic [SLOT_W-1:0]                res_slot;
    logic [mcrst_pkg::STATUS_W-1:0]   res_status;
    logic                             ws_inc, rs_inc, mask_arm, mask_clr;
    logic [SLOT_W-1:0]                cslot;
    logic [SLOT_W-1:0]                prev_wslot;
    logic [SEQ_W-1:0]                 ws_plus, rs_plus;
    logic [SLOT_W-1:0]                wslot_inc, rslot_inc;
    logic [NCONS-1:0]                 arm_mask;
    logic                             full, rs_caught, bad_id;

    assign ns = mcrst_pkg::eff_slots(slot_count_reg);
    assign nc = mcrst_pkg::eff_consumers(consumer_count_reg);

    assign status.out_busy    = m_valid_reg && !m_tready;
    assign status.slot_cfg_wr = cfg_wr_en && (cfg_addr == mcrst_pkg::CFG_SLOT_COUNT);
    assign status.nc_last     = mcrst_pkg::CID_W'(nc - 1'b1);

    // one read port over the read sequences
    assign addr    = cmd.exec ? req_id_reg : cmd.rd_addr;
    assign rs_sel  = rs_reg[addr];
    assign mod_val = cmd.mod_sel_ws ? ws_reg : rs_sel;
    assign nib     = 4'(mod_val >> {cmd.mod_digit, 2'b00});

    // fold one nibble into the running remainder, one bit per compare-subtract
    always_comb begin
        logic [SLOT_W-1:0] r;
        logic [SLOT_W:0]   t;
        r = cmd.mod_first ? '0 : rem_reg;
        for (int k = 3; k >= 0; k--) begin
            t = {r, nib[k]};
            if (t >= ns) r = SLOT_W'(t - ns);
            else r = t[SLOT_W-1:0];
        end
        rem_next = r;
    end

    always_comb begin
        for (int i = 0; i < NCONS; i++) begin
            arm_mask[i] = (mcrst_pkg::CONS_CNT_W'(i) < nc);
        end
    end

    assign ws_plus    = ws_reg + 1'b1;
    assign rs_plus    = rs_sel + 1'b1;
    assign cslot      = rslot_reg[req_id_reg];
    assign prev_wslot = (wslot_reg == '0) ? SLOT_W'(ns - 1'b1) : wslot_reg - 1'b1;
    assign wslot_inc  = (ws_plus == '0 || ({1'b0, wslot_reg} + 1'b1) == ns) ? '0
                                                                             : wslot_reg + 1'b1;
    assign rslot_inc  = (rs_plus == '0 || ({1'b0, cslot} + 1'b1) == ns) ? '0 : cslot + 1'b1;
    assign full       = (ws_reg - min_reg) >= SEQ_W'(ns);
    assign rs_caught  = rs_sel >= ws_reg;
    assign bad_id     = {1'b0, req_id_reg} >= nc;

    always_comb begin
        res_ok     = 1'b0;
        res_slot   = '0;
        res_status = mcrst_pkg::ST_OK;
        ws_inc     = 1'b0;
        rs_inc     = 1'b0;
        mask_arm   = 1'b0;
        mask_clr   = 1'b0;
        case (req_cmd_reg)
            mcrst_pkg::CMD_PROD_ACQ: begin
                if (full) begin
                    res_status = mcrst_pkg::ST_FULL;
                end else begin
                    res_ok   = 1'b1;
                    res_slot = wslot_reg;
                    ws_inc   = 1'b1;
                end
            end
            mcrst_pkg::CMD_PROD_REL: begin
                if (ws_reg == '0) begin
                    res_status = mcrst_pkg::ST_BAD;
                end else begin
                    res_ok   = 1'b1;
                    res_slot = prev_wslot;
                    mask_arm = 1'b1;
                end
            end
            mcrst_pkg::CMD_CONS_ACQ: begin
                if (bad_id) begin
                    res_status = mcrst_pkg::ST_BAD;
                end else if (rs_caught) begin
                    res_status = mcrst_pkg::ST_EMPTY;
                end else if (!mask_reg[cslot][req_id_reg]) begin
                    res_status = mcrst_pkg::ST_NOCLAIM;
                end else begin
                    res_ok   = 1'b1;
                    res_slot = cslot;
                    mask_clr = 1'b1;
                end
            end
            mcrst_pkg::CMD_CONS_REL: begin
                if (bad_id || rs_caught) begin
                    res_status = mcrst_pkg::ST_BAD;
                end else begin
                    res_ok   = 1'b1;
                    res_slot = cslot;
                    rs_inc   = 1'b1;
                end
            end
            default: begin
                res_status = mcrst_pkg::ST_BAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg     <= mcrst_pkg::SLOT_COUNT_RST;
            consumer_count_reg <= mcrst_pkg::CONSUMER_COUNT_RST;
            ws_reg             <= '0;
            wslot_reg          <= '0;
            m_valid_reg        <= 1'b0;
            for (int i = 0; i < NCONS; i++) begin
                rs_reg[i]    <= '0;
                rslot_reg[i] <= '0;
            end
            for (int j = 0; j < NSLOTS; j++) begin
                mask_reg[j] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    mcrst_pkg::CFG_SLOT_COUNT:     slot_count_reg <= cfg_wdata;
                    mcrst_pkg::CFG_CONSUMER_COUNT: consumer_count_reg <= cfg_wdata[3:0];
                    default: ;
                endcase
            end

            if (cmd.mod_wr) begin
                if (cmd.mod_sel_ws) wslot_reg <= rem_next;
                else rslot_reg[cmd.rd_addr] <= rem_next;
            end

            if (cmd.exec) begin
                if (ws_inc) begin
                    ws_reg    <= ws_plus;
                    wslot_reg <= wslot_inc;
                end
                if (rs_inc) begin
                    rs_reg[req_id_reg]    <= rs_plus;
                    rslot_reg[req_id_reg] <= rslot_inc;
                end
                if (mask_arm) mask_reg[prev_wslot] <= arm_mask;
                if (mask_clr) mask_reg[cslot][req_id_reg] <= 1'b0;
            end

            if (cmd.exec) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_cmd_reg <= in_cmd;
            req_id_reg  <= in_id;
            min_reg     <= '1;
        end else if (cmd.scan_step && rs_sel < min_reg) begin
            min_reg <= rs_sel;
        end
        if (cmd.mod_step) rem_reg <= rem_next;
        if (cmd.exec) m_data_reg <= {res_status, res_slot, res_ok};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    a_exec_into_free_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> !(m_valid_reg && !m_tready))
        else $error("result loaded over an unread result");

    a_exec_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid_reg)
        else $error("executed request left no result");
`endif

endmodule

FILE: hdl/multi_consumer_ring_slot_tracker.sv
// An accepted request goes to EXEC, which registers the result once the output is free; a
//   producer acquire first scans for the minimum read sequence in SCAN, one consumer per cycle.
// A new request is accepted only in IDLE, after the previous request has executed.
// A slot_count write blocks requests while the residue rebuild runs: it starts from IDLE,
//   then covers nine sequences at one nibble per cycle.
// Reset (aresetn low, synchronous) clears sequences, masks, residues and the output.
module multi_consumer_ring_slot_tracker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [mcrst_pkg::S_TDATA_W-1:0]       s_tdata,   // command[1:0], cons_sel[4:2]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mcrst_pkg::M_TDATA_W-1:0]       m_tdata,   // ok[0], slot[4:1], status[7:5]
    input  logic                                  cfg_wr_en,
    input  logic [mcrst_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mcrst_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    mcrst_pkg::ctrl_cmd_t   cmd;
    mcrst_pkg::dp_status_t  status;
    logic [mcrst_pkg::CMD_W-1:0] in_cmd;
    logic [mcrst_pkg::CID_W-1:0] in_id;

    assign in_cmd = s_tdata[mcrst_pkg::CMD_W-1:0];
    assign in_id  = s_tdata[mcrst_pkg::CMD_W +: mcrst_pkg::CID_W];

    mcrst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_cmd   (in_cmd),
        .status   (status),
        .cmd      (cmd)
    );

    mcrst_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_cmd    (in_cmd),
        .in_id     (in_id),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the ring slot tracker: directed plan, random phases, predictor.
`timescale 1ns / 100ps

module testbench;

    localparam int SEQ_W         = mcrst_pkg::SEQ_W;
    localparam int SLOT_W        = mcrst_pkg::SLOT_W;
    localparam int CID_W         = mcrst_pkg::CID_W;
    localparam int CMD_W         = mcrst_pkg::CMD_W;
    localparam int STATUS_W      = mcrst_pkg::STATUS_W;
    localparam int SLOT_CNT_W    = mcrst_pkg::SLOT_CNT_W;
    localparam int CONS_CNT_W    = mcrst_pkg::CONS_CNT_W;
    localparam int CFG_ADDR_W    = mcrst_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W    = mcrst_pkg::CFG_DATA_W;
    localparam int S_TDATA_W     = mcrst_pkg::S_TDATA_W;
    localparam int M_TDATA_W     = mcrst_pkg::M_TDATA_W;
    localparam int MAX_SLOTS     = mcrst_pkg::MAX_SLOTS;
    localparam int MAX_CONSUMERS = mcrst_pkg::MAX_CONSUMERS;

    localparam int CLK_PERIOD      = 8;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 172;
    localparam int HOLD_CYCLES     = 200;
    localparam int SETTLE_CYCLES   = 12;
    localparam int STALL_LIMIT     = 2000;
    localparam int NUM_DIRECTED    = 28;

    // same bit order as m_tdata
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                ok;
    } slot_result_t;

    typedef struct {
        bit                    is_reg;
        logic [CMD_W-1:0]      cmd;
        logic [CID_W-1:0]      cid;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        bit                    typed;
        slot_result_t          want;
    } plan_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    multi_consumer_ring_slot_tracker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // command[1:0], cons_sel[4:2]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // ok[0], slot[4:1], status[7:5]
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Ring state as the block should hold it
    logic [SEQ_W-1:0]         ring_wr_seq;
    logic [SEQ_W-1:0]         ring_rd_seq [MAX_CONSUMERS];
    logic [MAX_CONSUMERS-1:0] claim_mask  [MAX_SLOTS];
    logic [SLOT_CNT_W-1:0]    cfg_slots;
    logic [CONS_CNT_W-1:0]    cfg_consumers;
    bit                       producer_open;

    slot_result_t awaited_results [$];
    slot_result_t got, want;

    int unsigned gap_pct = 20;
    bit          hold_kick = 1'b0;
    int          hold_left = 0;
    int          stall_cycles = 0;
    int          errors = 0;
    int          requests_sent = 0;
    int          register_writes = 0;
    int          status_seen [8];

    logic [CFG_DATA_W-1:0] phase_slots [NUM_PHASES] = '{5'd16, 5'd1, 5'd16, 5'd4,
                                                        5'd0, 5'd31, 5'd0, 5'd0};
    logic [CFG_DATA_W-1:0] phase_cons  [NUM_PHASES] = '{5'd1, 5'd8, 5'd8, 5'd3,
                                                        5'd0, 5'd31, 5'd0, 5'd0};
    plan_row_t directed_plan [NUM_DIRECTED];

    function automatic logic [SLOT_CNT_W-1:0] active_slots();
        if (cfg_slots == '0) return SLOT_CNT_W'(1);
        if (cfg_slots > SLOT_CNT_W'(MAX_SLOTS)) return SLOT_CNT_W'(MAX_SLOTS);
        return cfg_slots;
    endfunction

    function automatic logic [CONS_CNT_W-1:0] active_consumers();
        if (cfg_consumers == '0) return CONS_CNT_W'(1);
        if (cfg_consumers > CONS_CNT_W'(MAX_CONSUMERS)) return CONS_CNT_W'(MAX_CONSUMERS);
        return cfg_consumers;
    endfunction

    function automatic void clear_ring();
        ring_wr_seq   = '0;
        cfg_slots     = mcrst_pkg::SLOT_COUNT_RST;
        cfg_consumers = mcrst_pkg::CONSUMER_COUNT_RST;
        producer_open = 1'b0;
        foreach (ring_rd_seq[i]) ring_rd_seq[i] = '0;
        foreach (claim_mask[i]) claim_mask[i] = '0;
    endfunction

    // Apply one request to the ring state and return the answer it earns
    function automatic slot_result_t apply_request(input logic [CMD_W-1:0] cmd,
                                                   input logic [CID_W-1:0] cid);
        logic [SLOT_CNT_W-1:0] ns;
        logic [CONS_CNT_W-1:0] nc;
        logic [SEQ_W-1:0]      low_rd;
        logic [SLOT_W-1:0]     idx;
        slot_result_t          r;
        ns = active_slots();
        nc = active_consumers();
        r  = '{status: mcrst_pkg::ST_OK, slot: '0, ok: 1'b0};
        if (cmd == mcrst_pkg::CMD_PROD_ACQ) begin
            low_rd = '1;
            for (int i = 0; i < MAX_CONSUMERS; i++)
                if (i < nc && ring_rd_seq[i] < low_rd) low_rd = ring_rd_seq[i];
            if (ring_wr_seq - low_rd >= SEQ_W'(ns)) begin
                r.status = mcrst_pkg::ST_FULL;
            end else begin
                r.ok   = 1'b1;
                r.slot = SLOT_W'(ring_wr_seq % ns);
                ring_wr_seq++;
                producer_open = 1'b1;
            end
        end else if (cmd == mcrst_pkg::CMD_PROD_REL) begin
            if (ring_wr_seq == '0) begin
                r.status = mcrst_pkg::ST_BAD;
            end else begin
                idx             = SLOT_W'((ring_wr_seq - 1) % ns);
                claim_mask[idx] = MAX_CONSUMERS'((9'd1 << nc) - 9'd1);
                r.ok            = 1'b1;
                r.slot          = idx;
                producer_open   = 1'b0;
            end
        end else if (CONS_CNT_W'(cid) >= nc) begin
            r.status = mcrst_pkg::ST_BAD;
        end else if (cmd == mcrst_pkg::CMD_CONS_ACQ) begin
            idx = SLOT_W'(ring_rd_seq[cid] % ns);
            if (ring_rd_seq[cid] >= ring_wr_seq) begin
                r.status = mcrst_pkg::ST_EMPTY;
            end else if (!claim_mask[idx][cid]) begin
                r.status = mcrst_pkg::ST_NOCLAIM;
            end else begin
                claim_mask[idx][cid] = 1'b0;
                r.ok   = 1'b1;
                r.slot = idx;
            end
        end else begin
            if (ring_rd_seq[cid] >= ring_wr_seq) begin
                r.status = mcrst_pkg::ST_BAD;
            end else begin
                r.ok   = 1'b1;
                r.slot = SLOT_W'(ring_rd_seq[cid] % ns);
                ring_rd_seq[cid]++;
            end
        end
        return r;
    endfunction

    // Mostly follow the producer/consumer protocol; the rest is noise
    function automatic void pick_request(output logic [CMD_W-1:0] cmd,
                                         output logic [CID_W-1:0] cid);
        int unsigned           roll;
        logic [CONS_CNT_W-1:0] nc;
        logic [SEQ_W-1:0]      rd;
        roll = $urandom_range(99);
        cid  = CID_W'($urandom_range(0, 7));
        cmd  = producer_open ? mcrst_pkg::CMD_PROD_REL : mcrst_pkg::CMD_PROD_ACQ;
        if (roll < 15) begin
            cmd = CMD_W'($urandom_range(0, 3));
        end else if (roll >= 50) begin
            nc  = active_consumers();
            cid = CID_W'($urandom_range(0, nc - 1));
            rd  = ring_rd_seq[cid];
            if (rd < ring_wr_seq) begin
                if (claim_mask[SLOT_W'(rd % active_slots())][cid])
                    cmd = mcrst_pkg::CMD_CONS_ACQ;
                else if (!(producer_open && rd == ring_wr_seq - 1))
                    cmd = mcrst_pkg::CMD_CONS_REL;
            end
        end
    endfunction

    function automatic plan_row_t known_row(input logic [CMD_W-1:0] cmd,
                                            input logic [CID_W-1:0] cid, input logic ok,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic [STATUS_W-1:0] status);
        plan_row_t row;
        row = '{is_reg: 1'b0, cmd: cmd, cid: cid, reg_idx: '0, reg_val: '0, typed: 1'b1,
                want: '{status: status, slot: slot, ok: ok}};
        return row;
    endfunction

    function automatic plan_row_t predicted_row(input logic [CMD_W-1:0] cmd,
                                                input logic [CID_W-1:0] cid);
        plan_row_t row;
        row = known_row(cmd, cid, 1'b0, '0, mcrst_pkg::ST_OK);
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_ADDR_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
        plan_row_t row;
        row = known_row(mcrst_pkg::CMD_PROD_ACQ, '0, 1'b0, '0, mcrst_pkg::ST_OK);
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = value;
        return row;
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CID_W-1:0] cid,
                                input bit typed, input slot_result_t typed_result);
        slot_result_t predicted;
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, cid, cmd};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_request(cmd, cid);
        awaited_results.push_back(typed ? typed_result : predicted);
        requests_sent++;
    endtask

    // Drop valid, then hold until every answer is back and the block has settled
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == mcrst_pkg::CFG_SLOT_COUNT) cfg_slots = value;
        else cfg_consumers = value[CONS_CNT_W-1:0];
        register_writes++;
        @(posedge aclk);
    endtask

    // Result side: random back-pressure, one long hold-off on request, check every answer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = slot_result_t'(m_tdata);
            status_seen[got.status]++;
            if (awaited_results.size() == 0) begin
                $error("unexpected result: tdata=%h", m_tdata);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                if (got.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, got.ok);
                    errors++;
                end
                if (got.slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, got.slot);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
            end
        end
        if (hold_kick) begin
            hold_kick = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= gap_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [CMD_W-1:0]      cmd;
        logic [CID_W-1:0]      cid;
        logic [CFG_DATA_W-1:0] slot_val;
        logic [CFG_DATA_W-1:0] cons_val;

        clear_ring();
        foreach (status_seen[i]) status_seen[i] = 0;
        directed_plan = '{
            known_row(mcrst_pkg::CMD_PROD_REL, 3'd0, 1'b0, 4'd0, mcrst_pkg::ST_BAD),
            known_row(mcrst_pkg::CMD_CONS_ACQ, 3'd0, 1'b0, 4'd0, mcrst_pkg::ST_EMPTY),
            known_row(mcrst_pkg::CMD_CONS_REL, 3'd0, 1'b0, 4'd0, mcrst_pkg::ST_BAD),
            known_row(mcrst_pkg::CMD_CONS_ACQ, 3'd1, 1'b0, 4'd0, mcrst_pkg::ST_BAD),
            known_row(mcrst_pkg::CMD_CONS_REL, 3'd7, 1'b0, 4'd0, mcrst_pkg::ST_BAD),
            known_row(mcrst_pkg::CMD_PROD_ACQ, 3'd0, 1'b1, 4'd0, mcrst_pkg::ST_OK),
            known_row(mcrst_pkg::CMD_CONS_ACQ, 3'd0, 1'b0, 4'd0, mcrst_pkg::ST_NOCLAIM),
            known_row(mcrst_pkg::CMD_PROD_REL, 3'd0, 1'b1, 4'd0, mcrst_pkg::ST_OK),
            known_row(mcrst_pkg::CMD_PROD_REL, 3'd0, 1'b1, 4'd0, mcrst_pkg::ST_OK),
            known_row(mcrst_pkg::CMD_CONS_ACQ, 3'd0, 1'b1, 4'd0, mcrst_pkg::ST_OK),
            known_row(mcrst_pkg::CMD_CONS_ACQ, 3'd0, 1'b0, 4'd0, mcrst_pkg::ST_NOCLAIM),
            known_row(mcrst_pkg::CMD_CONS_REL, 3'd0, 1'b1, 4'd0, mcrst_pkg::ST_OK),
            known_row(mcrst_pkg::CMD_CONS_REL, 3'd0, 1'b0, 4'd0, mcrst_pkg::ST_BAD),
            // zero slots acts as one, fifteen consumers as eight
            reg_row(mcrst_pkg::CFG_SLOT_COUNT, 5'd0),
            reg_row(mcrst_pkg::CFG_CONSUMER_COUNT, 5'd31),
            known_row(mcrst_pkg::CMD_PROD_ACQ, 3'd6, 1'b0, 4'd0, mcrst_pkg::ST_FULL),
            predicted_row(mcrst_pkg::CMD_PROD_REL, 3'd0),
            predicted_row(mcrst_pkg::CMD_CONS_ACQ, 3'd5),
            predicted_row(mcrst_pkg::CMD_CONS_REL, 3'd5),
            predicted_row(mcrst_pkg::CMD_CONS_ACQ, 3'd5),
            // oversized slot count clamps; consumer bit 4 is dropped, leaving zero
            reg_row(mcrst_pkg::CFG_SLOT_COUNT, 5'd31),
            reg_row(mcrst_pkg::CFG_CONSUMER_COUNT, 5'd16),
            predicted_row(mcrst_pkg::CMD_PROD_ACQ, 3'd0),
            known_row(mcrst_pkg::CMD_CONS_ACQ, 3'd3, 1'b0, 4'd0, mcrst_pkg::ST_BAD),
            predicted_row(mcrst_pkg::CMD_PROD_REL, 3'd2),
            predicted_row(mcrst_pkg::CMD_CONS_ACQ, 3'd0),
            predicted_row(mcrst_pkg::CMD_CONS_REL, 3'd0),
            known_row(mcrst_pkg::CMD_CONS_REL, 3'd4, 1'b0, 4'd0, mcrst_pkg::ST_BAD)
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_reg) begin
                wait_drained();
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
            end else begin
                send_request(directed_plan[i].cmd, directed_plan[i].cid,
                             directed_plan[i].typed, directed_plan[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            slot_val = (p >= 6) ? CFG_DATA_W'($urandom_range(0, 31)) : phase_slots[p];
            cons_val = (p >= 6) ? CFG_DATA_W'($urandom_range(0, 31)) : phase_cons[p];
            write_reg(mcrst_pkg::CFG_SLOT_COUNT, slot_val);
            write_reg(mcrst_pkg::CFG_CONSUMER_COUNT, cons_val);
            gap_pct = (p == 3) ? 0 : 20;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // stall the result side while requests keep coming
                if (p == 2 && n == 20) hold_kick = 1'b1;
                if (p == 5 && n == 80) wait_drained();
                pick_request(cmd, cid);
                send_request(cmd, cid, 1'b0, '0);
            end
        end

        wait_drained();
        $display("Covered %0d requests across %0d register writes.",
                 requests_sent, register_writes);
        $display("Answers: ok %0d, full %0d, empty %0d, unclaimable %0d, rejected %0d.",
                 status_seen[mcrst_pkg::ST_OK], status_seen[mcrst_pkg::ST_FULL],
                 status_seen[mcrst_pkg::ST_EMPTY], status_seen[mcrst_pkg::ST_NOCLAIM],
                 status_seen[mcrst_pkg::ST_BAD]);
        if (errors == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/mcrst_pkg.sv
hdl/mcrst_ctrl.sv
hdl/mcrst_dp.sv
hdl/multi_consumer_ring_slot_tracker.sv
test/testbench.sv
